### rtl/mau_pkg.sv
package mau_pkg;

  typedef enum logic [1:0] {
    OP_NORM = 2'd0,
    OP_ADD  = 2'd1,
    OP_MUL  = 2'd2,
    OP_INV  = 2'd3
  } op_e;

  // Shared divider request; the response comes back on separate ports.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_NORM_FIX,
    ST_ADD,
    ST_MUL_STEP,
    ST_INV_CHECK,
    ST_INV_DIV,
    ST_INV_Q,
    ST_INV_MUL,
    ST_INV_UPD,
    ST_DONE
  } state_e;

endpackage

### rtl/mau_divider.sv
module mau_divider #(
  parameter int W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mau_pkg::div_ctrl_t ctrl_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         busy_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  import mau_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  den_q;
  logic [W-1:0]  quot_q;
  logic [W-1:0]  rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // One quotient bit per cycle, restoring.
  assign trial = {rem_q, quot_q[W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      den_q  <= den_i;
      quot_q <= num_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_q  <= diff[W-1:0];
        quot_q <= {quot_q[W-2:0], 1'b1};
      end else begin
        rem_q  <= trial[W-1:0];
        quot_q <= {quot_q[W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

### rtl/mau_addmod.sv
module mau_addmod #(
  parameter int W = 64
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic [W-1:0] sum_o
);
  import mau_pkg::*;

  logic [W-1:0] gap;

  // Operands are already reduced below the modulus.
  assign gap   = m_i - b_i;
  assign sum_o = (a_i >= gap) ? (a_i - gap) : (a_i + b_i);
endmodule

### rtl/modular_arithmetic_unit_top.sv
// All operations first reduce the operands on the shared restoring divider, which
// produces one quotient bit per cycle while busy; normalize and add then finish directly.
// Multiply then runs double-and-add steps on the shared adder.
// Inverse runs per Euclid step a division, the adder steps and the bookkeeping
// states ST_INV_CHECK, ST_INV_Q and ST_INV_UPD. One request at a time; the next request
// can be taken in the cycle after the result is accepted. Reset returns to idle.
module modular_arithmetic_unit_top #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  input  logic [63:0] modulus_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_value_o,
  output logic        ok_o
);
  import mau_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};

  state_e state_q, state_d;
  logic [1:0]   op_q;
  logic [W-1:0] a_q, b_q, m_q;
  logic         neg_q;
  logic [W-1:0] r0_q, r1_q, c0_q, c1_q, q_q;
  logic [W-1:0] acc_q, x_q, y_q;
  logic [W-1:0] res_q;
  logic         ok_q;
  logic         wait_q;
  div_ctrl_t    dctl;
  logic [W-1:0] dnum, dden;
  logic         dbusy;
  logic [W-1:0] dquot, drem;
  logic [W-1:0] add_a, add_b, add_s;
  logic [W-1:0] mag_a, nr;

  mau_divider #(.W(W)) u_div (
    .clk_i, .rst_ni, .ctrl_i(dctl), .num_i(dnum), .den_i(dden),
    .busy_o(dbusy), .quot_o(dquot), .rem_o(drem)
  );

  mau_addmod #(.W(W)) u_add (
    .a_i(add_a), .b_i(add_b), .m_i(m_q), .sum_o(add_s)
  );

  assign mag_a = neg_q ? (W'(0) - a_q) : a_q;

  always_comb begin
    add_a = acc_q;
    add_b = x_q;
    if (state_q == ST_ADD) begin
      add_a = r0_q;
      add_b = drem;
    end else if ((state_q == ST_MUL_STEP || state_q == ST_INV_MUL) && !y_q[0]) begin
      add_a = x_q;
      add_b = x_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RED_A;
        end
      end
      ST_RED_A: begin
        if (!wait_q && !dbusy) begin
          state_d = ST_RED_B;
        end
      end
      ST_RED_B: begin
        if (!wait_q && !dbusy) begin
          unique case (op_q)
            OP_NORM: state_d = ST_NORM_FIX;
            OP_ADD:  state_d = ST_ADD;
            OP_MUL:  state_d = ST_MUL_STEP;
            default: state_d = ST_INV_CHECK;
          endcase
        end
      end
      ST_NORM_FIX:  state_d = ST_DONE;
      ST_ADD:       state_d = ST_DONE;
      ST_MUL_STEP: begin
        if (y_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_INV_CHECK: state_d = (r1_q == '0) ? ST_DONE : ST_INV_DIV;
      ST_INV_DIV: begin
        if (!wait_q && !dbusy) begin
          state_d = ST_INV_Q;
        end
      end
      ST_INV_Q:     state_d = ST_INV_MUL;
      ST_INV_MUL: begin
        if (y_q == '0) begin
          state_d = ST_INV_UPD;
        end
      end
      ST_INV_UPD:   state_d = ST_INV_CHECK;
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dctl.start = 1'b0;
    dnum = mag_a;
    dden = m_q;
    unique case (state_q)
      ST_RED_A:   dctl.start = wait_q;
      ST_RED_B: begin
        dctl.start = wait_q;
        dnum = b_q;
      end
      ST_INV_DIV: begin
        dctl.start = wait_q;
        dnum = r0_q;
        dden = r1_q;
      end
      default: ;
    endcase
  end

  assign nr = drem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= (state_d != state_q) &&
                 (state_d == ST_RED_A || state_d == ST_RED_B || state_d == ST_INV_DIV);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        op_q  <= opcode_i;
        a_q   <= operand_a_i[W-1:0];
        b_q   <= operand_b_i[W-1:0];
        m_q   <= modulus_i[W-1:0];
        neg_q <= (opcode_i == OP_NORM || opcode_i == OP_INV) && operand_a_i[W-1];
      end
      ST_RED_A: begin
        if (!wait_q && !dbusy) begin
          r0_q <= drem;
        end
      end
      ST_RED_B: begin
        if (!wait_q && !dbusy) begin
          acc_q <= '0;
          x_q   <= r0_q;
          y_q   <= drem;
          if (op_q == OP_NORM) begin
            res_q <= (m_q == '0) ? a_q
                     : ((neg_q && r0_q != '0) ? (m_q - r0_q) : r0_q);
            ok_q  <= 1'b1;
          end
          if (op_q == OP_INV) begin
            c0_q <= '0;
            c1_q <= {{(W-1){1'b0}}, 1'b1};
            if (m_q <= {{(W-1){1'b0}}, 1'b1} || m_q > SIGN) begin
              r1_q <= '0;
              r0_q <= '0;
            end else begin
              r1_q <= (neg_q && r0_q != '0) ? (m_q - r0_q) : r0_q;
              r0_q <= m_q;
            end
          end
        end
      end
      ST_ADD: begin
        res_q <= (m_q == '0) ? '0 : add_s;
        ok_q  <= (m_q != '0);
      end
      ST_MUL_STEP, ST_INV_MUL: begin
        if (y_q != '0) begin
          if (y_q[0]) begin
            acc_q <= add_s;
            y_q   <= y_q & ~{{(W-1){1'b0}}, 1'b1};
          end else begin
            x_q <= add_s;
            y_q <= y_q >> 1;
          end
        end
        if (state_q == ST_MUL_STEP && y_q == '0) begin
          res_q <= (m_q == '0) ? '0 : acc_q;
          ok_q  <= (m_q != '0);
        end
      end
      ST_INV_CHECK: begin
        if (r1_q == '0) begin
          ok_q  <= (r0_q == {{(W-1){1'b0}}, 1'b1});
          res_q <= (r0_q == {{(W-1){1'b0}}, 1'b1}) ? c0_q : '0;
        end
      end
      ST_INV_DIV: begin
        if (!wait_q && !dbusy) begin
          q_q <= dquot;
        end
      end
      ST_INV_Q: begin
        // q < m except when r1 is 1; reduce q so the adder sees residues.
        acc_q <= '0;
        x_q   <= (q_q >= m_q) ? (q_q - m_q) : q_q;
        y_q   <= c1_q;
        r0_q  <= r1_q;
        r1_q  <= nr;
      end
      ST_INV_UPD: begin
        c0_q <= c1_q;
        c1_q <= (c0_q >= acc_q) ? (c0_q - acc_q) : (m_q - (acc_q - c0_q));
      end
      default: ;
    endcase
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = (state_q == ST_DONE);
  assign result_value_o = 64'(res_q);
  assign ok_o           = ok_q;
endmodule

### tb/modular_arithmetic_unit_top_tb.sv
`timescale 1ns / 1ps

module modular_arithmetic_unit_top_tb;
  import mau_pkg::*;

  class mod_result_board;
    logic [63:0] exp_value_q[$];
    logic        exp_ok_q[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function logic [63:0] residue(logic [63:0] v, logic [63:0] m);
      logic [63:0] mag;
      logic [63:0] r;
      if (m == 64'd0) return v;
      mag = v[63] ? (64'd0 - v) : v;
      r = mag % m;
      return (v[63] && r != 64'd0) ? m - r : r;
    endfunction

    function logic [63:0] sum_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] s;
      s = {64'd0, a % m} + {64'd0, b % m};
      return 64'(s % {64'd0, m});
    endfunction

    function logic [63:0] prod_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] p;
      p = {64'd0, a % m} * {64'd0, b % m};
      return 64'(p % {64'd0, m});
    endfunction

    function logic inverse(logic [63:0] v, logic [63:0] m, output logic [63:0] res);
      logic [63:0] r0, r1, c0, c1, q, nr, p, nc;
      res = 64'd0;
      if (m <= 64'd1 || m > (64'd1 << 63)) return 1'b0;
      r0 = m;
      r1 = residue(v, m);
      c0 = 64'd0;
      c1 = 64'd1;
      while (r1 != 64'd0) begin
        q = r0 / r1;
        nr = r0 % r1;
        p = prod_mod(q, c1, m);
        nc = (c0 >= p) ? c0 - p : m - (p - c0);
        r0 = r1;
        r1 = nr;
        c0 = c1;
        c1 = nc;
      end
      if (r0 != 64'd1) return 1'b0;
      res = c0;
      return 1'b1;
    endfunction

    function void note_request(op_e op, logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] val;
      logic        ok;
      val = 64'd0;
      ok = 1'b0;
      case (op)
        OP_NORM: begin
          val = residue(a, m);
          ok = 1'b1;
        end
        OP_ADD: begin
          if (m != 64'd0) begin
            val = sum_mod(a, b, m);
            ok = 1'b1;
          end
        end
        OP_MUL: begin
          if (m != 64'd0) begin
            val = prod_mod(a, b, m);
            ok = 1'b1;
          end
        end
        default: begin
          ok = inverse(a, m, val);
          if (!ok) val = 64'd0;
        end
      endcase
      exp_value_q.push_back(val);
      exp_ok_q.push_back(ok);
    endfunction

    function void check_result(logic [63:0] val, logic ok);
      logic [63:0] e_val;
      logic        e_ok;
      if (exp_value_q.size() == 0) begin
        $display("%0t: unexpected result value=%h ok=%b", $time, val, ok);
        errors++;
        return;
      end
      e_val = exp_value_q.pop_front();
      e_ok = exp_ok_q.pop_front();
      if (val !== e_val) begin
        $display("%0t: result_value expected %h actual %h", $time, e_val, val);
        errors++;
      end
      if (ok !== e_ok) begin
        $display("%0t: ok expected %b actual %b", $time, e_ok, ok);
        errors++;
      end
    endfunction

    function int pending();
      return exp_value_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [63:0] operand_a_i;
  logic [63:0] operand_b_i;
  logic [63:0] modulus_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] result_value_o;
  logic        ok_o;

  mod_result_board board = new();

  modular_arithmetic_unit_top #(.DATA_WIDTH(64)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .opcode_i(opcode_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .modulus_i(modulus_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_value_o(result_value_o),
    .ok_o(ok_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic send_request(op_e op, logic [63:0] a, logic [63:0] b, logic [63:0] m);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    modulus_i <= m;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(op, a, b, m);
  endtask

  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_modulus();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'(1) << 63;
      3: return (64'(1) << 63) + 64'($urandom_range(0, 3));
      4: return ~64'd0 - 64'($urandom_range(0, 3));
      5, 6: return 64'($urandom_range(2, 1000));
      7: return 64'($urandom);
      default: return rand_word();
    endcase
  endfunction

  initial begin
    int burst;
    in_valid_i = 1'b0;
    opcode_i = OP_NORM;
    operand_a_i = 64'd0;
    operand_b_i = 64'd0;
    modulus_i = 64'd0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(OP_NORM, 64'h1234_5678_9abc_def0, rand_word(), 64'd0);
    send_request(OP_NORM, ~64'd0, rand_word(), 64'd7);
    send_request(OP_NORM, 64'h8000_0000_0000_0000, 64'd0, 64'd3);
    send_request(OP_NORM, 64'h7fff_ffff_ffff_ffff, 64'd0, ~64'd0);
    send_request(OP_NORM, 64'hffff_ffff_ffff_fff9, 64'd0, 64'd7);
    send_request(OP_ADD, 64'd5, 64'd6, 64'd0);
    send_request(OP_ADD, ~64'd0, ~64'd0, ~64'd0);
    send_request(OP_ADD, ~64'd0 - 64'd1, ~64'd0 - 64'd2, ~64'd0);
    send_request(OP_ADD, ~64'd0, ~64'd0, 64'd5);
    send_request(OP_MUL, 64'd3, 64'd4, 64'd0);
    send_request(OP_MUL, ~64'd0, ~64'd0, 64'd1);
    send_request(OP_MUL, ~64'd0 - 64'd1, ~64'd0 - 64'd1, ~64'd0);
    send_request(OP_MUL, 64'd0, ~64'd0, 64'd17);
    send_request(OP_INV, 64'd3, 64'd0, 64'd0);
    send_request(OP_INV, 64'd3, 64'd0, 64'd1);
    send_request(OP_INV, 64'd3, ~64'd0, 64'(1) << 63);
    send_request(OP_INV, 64'd3, 64'd0, (64'(1) << 63) + 64'd1);
    send_request(OP_INV, 64'd6, 64'd0, 64'd9);
    send_request(OP_INV, ~64'd0, 64'd0, 64'd7);
    send_request(OP_INV, 64'd0, 64'd0, 64'd5);
    send_request(OP_INV, 64'h8000_0000_0000_0001, 64'd0, 64'h7fff_ffff_ffff_ffe7);
    send_request(OP_INV, 64'd1, 64'd0, 64'd2);

    for (int i = 0; i < 80; i++) begin
      if (i == 40) wait_drained();
      burst = $urandom_range(0, 3);
      if (burst == 0) idle_sender($urandom_range(1, 20));
      send_request(op_e'($urandom_range(0, 3)), rand_word(), rand_word(), rand_modulus());
    end
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int cycle;
    int rx_mode;
    int hold_left;
    cycle = 0;
    rx_mode = 0;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      cycle++;
      if (cycle == 3000 || cycle == 60000) hold_left = 500;
      if (cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= (cycle % 4 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(result_value_o, ok_o);
    end
  end

  initial begin
    #200ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
